// File: hdl/xsfb_pkg.sv
// Shared constants, types and helpers for the XOR sprite frame buffer.
`timescale 1ns / 1ps
package xsfb_pkg;

	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 32;
	localparam int SPRITE_BITS   = 8;
	localparam int COORD_W       = 8;

	// Coordinates wrap by masking: both screen dimensions are powers of two.
	localparam int COL_W = $clog2(SCREEN_WIDTH);
	localparam int ROW_W = $clog2(SCREEN_HEIGHT);

	typedef enum logic [1:0] {
		OP_PLOT  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef logic [SCREEN_WIDTH-1:0] row_word_t;

	typedef struct packed {
		logic      wr_en;
		logic      clr_all;
		row_word_t wr_data;
		logic      collision;
		logic      pixel;
	} eng_res_t;

	// Sprite bits placed at column start and rotated so that columns past
	// the right edge land at the left edge of the same row.
	function automatic row_word_t sprite_mask(input logic [SPRITE_BITS-1:0] sprite,
			input logic [COL_W-1:0] start);
		logic [2*SCREEN_WIDTH-1:0] wide;
		wide = {{(2*SCREEN_WIDTH-SPRITE_BITS){1'b0}}, sprite} << start;
		return wide[SCREEN_WIDTH-1:0] | wide[2*SCREEN_WIDTH-1:SCREEN_WIDTH];
	endfunction

endpackage

// File: hdl/xsfb_row_ram.sv
// Generic single-port-write, registered-read RAM holding one screen row per entry.
`timescale 1ns / 1ps
module xsfb_row_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/xsfb_row_engine.sv
// Modify step: XOR a sprite row into a fetched screen row, or pick one pixel.
`timescale 1ns / 1ps
module xsfb_row_engine import xsfb_pkg::*; (
	input  op_t                    op,
	input  logic                   row_valid,
	input  row_word_t              rd_data,
	input  logic [SPRITE_BITS-1:0] sprite,
	input  logic [COL_W-1:0]       col,
	output eng_res_t               res
);

	row_word_t old_row;
	row_word_t mask;

	// A row never written since the last clear reads as all dark.
	assign old_row = row_valid ? rd_data : '0;
	assign mask    = sprite_mask(sprite, col);

	always_comb begin
		res = '0;
		unique case (op)
			OP_PLOT: begin
				res.wr_en     = 1'b1;
				res.wr_data   = old_row ^ mask;
				res.collision = |(old_row & mask);
			end
			OP_CLEAR: begin
				res.clr_all = 1'b1;
			end
			OP_READ: begin
				res.pixel = old_row[col];
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

// File: hdl/xor_sprite_framebuffer_top.sv
// Top level of the XOR sprite frame buffer: stream ports, sequencing and row memory.
`timescale 1ns / 1ps
// Monochrome 64x32 frame buffer, one row of pixels per memory word. The row
// is read from the synchronous row memory in the accept cycle, then modified
// and written back once the output register can take the result; a new beat
// is not taken until the current one has completed. A plot XORs eight
// sprite pixels into one row, wrapping past the right edge; a read returns one
// pixel; a clear is handled like any other beat, since per-row valid flags mark
// rows as dark instead of sweeping the memory. Reset needs no clearing pass.
module xor_sprite_framebuffer_top import xsfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pos_x[7:0], pos_y[15:8], sprite_row[23:16]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // collision[0], pixel[1], zero[7:2]
);

	logic                   busy_s1;
	op_t                    op_s1;
	logic [ROW_W-1:0]       row_s1;
	logic [COL_W-1:0]       col_s1;
	logic [SPRITE_BITS-1:0] sprite_s1;

	logic [SCREEN_HEIGHT-1:0] row_valid_q;
	logic                     m_tvalid_q;
	logic                     collision_q;
	logic                     pixel_q;

	logic      accept;
	logic      complete;
	row_word_t rd_data;
	eng_res_t  res;

	assign s_tready = !busy_s1;
	assign accept   = s_tvalid && s_tready;
	// The fetched row is finished once the output register can take the result.
	assign complete = busy_s1 && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (complete) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op_t'(s_tuser);
			col_s1    <= s_tdata[COL_W-1:0];
			row_s1    <= s_tdata[COORD_W +: ROW_W];
			sprite_s1 <= s_tdata[2*COORD_W +: SPRITE_BITS];
		end
	end

	xsfb_row_ram #(
		.DEPTH(SCREEN_HEIGHT),
		.WIDTH(SCREEN_WIDTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (complete && res.wr_en),
		.wr_addr(row_s1),
		.wr_data(res.wr_data),
		.rd_en  (accept),
		.rd_addr(s_tdata[COORD_W +: ROW_W]),
		.rd_data(rd_data)
	);

	xsfb_row_engine u_engine (
		.op       (op_s1),
		.row_valid(row_valid_q[row_s1]),
		.rd_data  (rd_data),
		.sprite   (sprite_s1),
		.col      (col_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (complete) begin
			if (res.clr_all) begin
				row_valid_q <= '0;
			end else if (res.wr_en) begin
				row_valid_q[row_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (complete) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			collision_q <= res.collision;
			pixel_q     <= res.pixel;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, pixel_q, collision_q};

endmodule
